[design/gfm_pkg.sv]
// Package for the GF(2^128) GCM multiplier: lane type, field width and
// reduction feedback constant. No dependencies.
package gfm_pkg;

  // Field element width and default bits of the multiplier consumed per cell
  localparam int GFM_WIDTH     = 128;
  localparam int GFM_CELL_BITS = 8;

  // x^128 = x^7 + x^2 + x + 1 (0x87), reflected: 0xE1 in the top byte
  localparam logic [GFM_WIDTH-1:0] GFM_FEEDBACK = {8'hE1, {(GFM_WIDTH-8){1'b0}}};

  // Data carried from cell to cell
  typedef struct packed {
    logic [GFM_WIDTH-1:0] x;  // multiplier, next coefficient in the top bit
    logic [GFM_WIDTH-1:0] z;  // partial product
    logic [GFM_WIDTH-1:0] v;  // multiplicand times x^k, reduced
  } gfm_lane_t;

endpackage

[design/gfm_cell.sv]
// One cell of the multiplier chain: consumes CELL_BITS multiplier coefficients
// and registers the updated lane. Depends on gfm_pkg.
module gfm_cell
  import gfm_pkg::*;
#(
  parameter int CELL_BITS = GFM_CELL_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  gfm_lane_t up_lane,
  output logic      dn_valid,
  input  logic      dn_ready,
  output gfm_lane_t dn_lane
);

  logic      valid_r;
  logic      valid_nxt;
  gfm_lane_t lane_r;
  gfm_lane_t lane_nxt;
  logic [GFM_WIDTH-1:0] x_w;
  logic [GFM_WIDTH-1:0] z_w;
  logic [GFM_WIDTH-1:0] v_w;
  logic                 carry_w;

  // Accept when empty or when the downstream cell takes our transaction
  assign up_ready = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // Shift-and-add over this cell's coefficients, reducing V at each step
  always_comb begin
    x_w = up_lane.x;
    z_w = up_lane.z;
    v_w = up_lane.v;
    carry_w = 1'b0;
    for (int j = 0; j < CELL_BITS; j++) begin
      if (x_w[GFM_WIDTH-1]) begin
        z_w = z_w ^ v_w;
      end
      carry_w = v_w[0];
      v_w = v_w >> 1;
      if (carry_w) begin
        v_w = v_w ^ GFM_FEEDBACK;
      end
      x_w = x_w << 1;
    end
    lane_nxt.x = x_w;
    lane_nxt.z = z_w;
    lane_nxt.v = v_w;
  end

  // Hold the valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the lane on each accepted transaction
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      lane_r <= lane_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lane  = lane_r;

endmodule

[design/gf128_gcm_multiply_core.sv]
// GF(2^128) multiplier in GCM bit order: top level, a chain of gfm_cell
// stages with valid/ready flow control. Depends on gfm_pkg and gfm_cell.
//
// Multiplies two 128-bit field elements modulo x^128 + x^7 + x^2 + x + 1 in
// GCM bit order (bit 63 of a_high is the coefficient of x^0). The work runs
// through a row of 128/CELL_BITS cells (16 with the default of 8 bits per
// cell), each handling CELL_BITS multiplier coefficients and registering its
// lane, so a transaction passes through every cell register on its way out,
// and a new one can be accepted every cycle unless the output stalls. The last
// cell's register is the output register; when the output stalls the chain
// fills and in_ready falls once every cell holds a transaction. in_ready is a
// combinational function of out_ready through the cell chain. The block has
// no state beyond the pipeline; reset only empties the chain.
module gf128_gcm_multiply_core
  import gfm_pkg::*;
#(
  parameter int CELL_BITS = GFM_CELL_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_b_high,
  input  logic [63:0] in_b_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_prod_high,
  output logic [63:0] out_prod_low
);

  localparam int NUM_CELLS = GFM_WIDTH / CELL_BITS;

  gfm_lane_t            lane_w  [NUM_CELLS+1];
  logic [NUM_CELLS:0]   vld_w;
  logic [NUM_CELLS:0]   rdy_w;

  // Seed the first cell: X = a, Z = 0, V = b
  assign lane_w[0].x = {in_a_high, in_a_low};
  assign lane_w[0].z = '0;
  assign lane_w[0].v = {in_b_high, in_b_low};
  assign vld_w[0]    = in_valid;
  assign in_ready    = rdy_w[0];

  // Build the chain of cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    gfm_cell #(
      .CELL_BITS (CELL_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_w[i]),
      .up_ready (rdy_w[i]),
      .up_lane  (lane_w[i]),
      .dn_valid (vld_w[i+1]),
      .dn_ready (rdy_w[i+1]),
      .dn_lane  (lane_w[i+1])
    );
  end

  // Drive the result channel from the last cell
  assign rdy_w[NUM_CELLS] = out_ready;
  assign out_valid        = vld_w[NUM_CELLS];
  assign out_prod_high    = lane_w[NUM_CELLS].z[GFM_WIDTH-1:64];
  assign out_prod_low     = lane_w[NUM_CELLS].z[63:0];

  // Input may stall only when every cell holds a transaction
  a_full_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_w[NUM_CELLS:1]))
    else $error("input blocked while the cell chain has a free slot");

  // An accepted transaction lands in the first cell
  a_first_cell_loads : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_w[1])
    else $error("accepted transaction missing from the first cell");

  // Each valid cell has shifted out its share of multiplier coefficients
  for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_chk
    a_coeffs_consumed : assert property (@(posedge clk) disable iff (!rst_n)
      vld_w[k] |-> (lane_w[k].x[CELL_BITS*k-1:0] == {(CELL_BITS*k){1'b0}}))
      else $error("multiplier not shifted by the expected amount");
  end

endmodule

[tb/sv/tb_gf128_gcm_multiply_core.sv]
// Testbench for gf128_gcm_multiply_core: drives operand pairs through the
// valid/ready channels and checks each product against a bit-serial GHASH
// multiply kept here. Depends on gfm_pkg and the core RTL.
module tb_gf128_gcm_multiply_core
  import gfm_pkg::*;
();

  typedef struct {
    logic [63:0] prod_high;
    logic [63:0] prod_low;
  } gcm_product_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_a_high;
  logic [63:0] in_a_low;
  logic [63:0] in_b_high;
  logic [63:0] in_b_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_prod_high;
  logic [63:0] out_prod_low;

  gcm_product_t pending_products[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  bit           src_idle = 1'b0;      // sender inserts random gaps
  bit           sink_stalls = 1'b0;   // receiver drops ready at random
  int unsigned  sink_hold_len = 0;    // one-off long receiver hold-off

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned DRAIN_CYCLES  = 48;

  gf128_gcm_multiply_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_a_high    (in_a_high),
    .in_a_low     (in_a_low),
    .in_b_high    (in_b_high),
    .in_b_low     (in_b_low),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_prod_high(out_prod_high),
    .out_prod_low (out_prod_low)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Field multiply in GCM bit order: bit 127 is the coefficient of x^0
  function automatic logic [127:0] gcm_field_product(logic [127:0] x, logic [127:0] y);
    logic [127:0] z;
    logic [127:0] v;
    logic         carry;
    z = '0;
    v = y;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z ^= v;
      // multiply v by x: a right shift, folding x^128 back in
      carry = v[0];
      v = v >> 1;
      if (carry) v ^= GFM_FEEDBACK;
    end
    return z;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Operand shapes: dense random, sparse, zero/identity, repeated byte
  function automatic logic [127:0] pick_operand();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return {$urandom, $urandom, $urandom, $urandom};
    if (roll < 80) return 128'd1 << $urandom_range(0, 127);
    if (roll < 85) return '0;
    if (roll < 90) return {1'b1, 127'd0};
    return {16{8'($urandom)}};
  endfunction

  // Offer one transaction, hold it until accepted, then maybe go idle
  task automatic send_operands(logic [127:0] a, logic [127:0] b);
    logic [127:0] product;
    int unsigned  gap;
    in_valid  <= 1'b1;
    in_a_high <= a[127:64];
    in_a_low  <= a[63:0];
    in_b_high <= b[127:64];
    in_b_low  <= b[63:0];
    do @(posedge clk); while (!in_ready);
    product = gcm_field_product(a, b);
    pending_products.push_back('{prod_high: product[127:64], prod_low: product[63:0]});
    gap = src_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver ready: random stalls plus the requested long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        stall_left = sink_hold_len;
        sink_hold_len = 0;
      end else if (stall_left == 0 && sink_stalls && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each accepted product with the oldest prediction
  always @(posedge clk) begin
    gcm_product_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        $error("unexpected product %h_%h", out_prod_high, out_prod_low);
        mismatch_count++;
      end else begin
        want = pending_products.pop_front();
        if (out_prod_high !== want.prod_high) begin
          $error("prod_high: expected %h, got %h", want.prod_high, out_prod_high);
          mismatch_count++;
        end
        if (out_prod_low !== want.prod_low) begin
          $error("prod_low: expected %h, got %h", want.prod_low, out_prod_low);
          mismatch_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gf128_gcm_multiply_core verification failed");
      $finish;
    end
  end

  // Zero, one, all-ones, top coefficient wrap, swapped pairs, stripes
  task automatic test_directed_operands();
    logic [127:0] one;
    logic [127:0] ones;
    logic [127:0] r1;
    logic [127:0] r2;
    one  = {1'b1, 127'd0};
    ones = '1;
    r1   = {$urandom, $urandom, $urandom, $urandom};
    r2   = {$urandom, $urandom, $urandom, $urandom};
    src_idle    = 1'b0;
    sink_stalls = 1'b0;
    send_operands('0, '0);
    send_operands('0, ones);
    send_operands(ones, '0);
    send_operands(one, one);
    send_operands(one, r1);
    send_operands(r1, one);
    send_operands(ones, ones);
    send_operands(ones, one);
    send_operands(128'd1, 128'd1);
    send_operands(128'd1, {2'b01, 126'd0});
    send_operands(128'd1, ones);
    send_operands(r1, r2);
    send_operands(r2, r1);
    send_operands({64'hFFFF_FFFF_FFFF_FFFF, 64'd0}, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF});
    send_operands({64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, {64'hFFFF_FFFF_FFFF_FFFF, 64'd0});
    send_operands({16{8'hAA}}, {16{8'h55}});
    send_operands({16{8'h55}}, {16{8'hAA}});
    send_operands({8{16'h8001}}, {8{16'h0180}});
    send_operands({64'h8000_0000_0000_0000, 64'd1}, r2);
    send_operands(128'd1 << 64, 128'd1 << 63);
  endtask

  // Hold the receiver off long enough for the chain to fill and stall input
  task automatic test_back_pressure();
    src_idle      = 1'b0;
    sink_stalls   = 1'b0;
    sink_hold_len = 200;
    repeat (40) send_operands(pick_operand(), pick_operand());
  endtask

  // Back-to-back transactions with neither side idling
  task automatic test_streaming();
    src_idle    = 1'b0;
    sink_stalls = 1'b0;
    repeat (60) send_operands(pick_operand(), pick_operand());
  endtask

  // Random operands in chunks, each with its own idling mix
  task automatic test_random_operands();
    for (int chunk = 0; chunk < 17; chunk++) begin
      src_idle    = $urandom_range(0, 2) != 0;
      sink_stalls = $urandom_range(0, 2) != 0;
      repeat (50) send_operands(pick_operand(), pick_operand());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_a_high = '0;
    in_a_low  = '0;
    in_b_high = '0;
    in_b_low  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_operands();
    test_back_pressure();
    test_streaming();
    test_random_operands();

    // Drop valid, drain, then allow for the pipeline depth
    in_valid <= 1'b0;
    sink_stalls = 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("gf128_gcm_multiply_core verification clean");
    end else begin
      $display("gf128_gcm_multiply_core verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/gfm_pkg.sv
design/gfm_cell.sv
design/gf128_gcm_multiply_core.sv
tb/sv/tb_gf128_gcm_multiply_core.sv
